// ===== rtl/core/cbf_pkg.sv =====
// Shared types and constants for the two-hash counting Bloom filter.
// No dependencies; imported by every module of the block but cbf_ram.
`default_nettype none
package cbf_pkg;

	// Opcodes carried on the last byte of a key
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_QUERY  = 2'd1,
		OP_DELETE = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 1'd1;
	localparam int CFG_DATA_W = 11;

	// Hash constants
	localparam logic [31:0] FNV_START = 32'd21661362;
	localparam logic [31:0] FNV_MUL   = 32'd16777619;
	localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2    = 32'h1b873593;
	localparam logic [31:0] MUR_ADD   = 32'he6546b64;
	localparam logic [31:0] MUR_F1    = 32'h85ebca6b;
	localparam logic [31:0] MUR_F2    = 32'hc2b2ae35;

	// Finished key handed from the hash front to the filter back
	typedef struct packed {
		logic [31:0] fnv;
		logic [31:0] mur;
		op_t         op;
	} key_job_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_MIX,
		F_FIN1,
		F_FIN2,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_MOD,
		B_INIT,
		B_SET,
		B_QRD,
		B_QCHK,
		B_CRD,
		B_CWR,
		B_CLR0,
		B_CLR1,
		B_OUT
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/cbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cbf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/cbf_front.sv =====
// Hash front: folds key bytes into the FNV-like and Murmur-like hashes and
// finalises them on the last byte. Depends on cbf_pkg.
`default_nettype none
module cbf_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                hold,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire [1:0]          opcode,
	input  wire [7:0]          key_byte,
	input  wire                last_byte,
	output logic               job_valid,
	input  wire                job_ready,
	output cbf_pkg::key_job_t  job
);
	import cbf_pkg::*;

	front_state_t state_q, state_d;
	logic [31:0] fnv_q, mur_q, k_q;
	logic        last_q;
	logic [1:0]  op_q;
	logic [31:0] x, hx, hr, ft;

	assign x  = {{24{key_byte[7]}}, key_byte};
	assign hx = mur_q ^ k_q;
	assign hr = (hx << 13) | (hx >> 13);
	assign ft = mur_q ^ (mur_q >> 13);

	assign job.fnv = fnv_q;
	assign job.mur = mur_q ^ (mur_q >> 16);
	assign job.op  = op_t'(op_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		job_valid = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_ready = !hold;
				if (in_valid && !hold) state_d = F_MUL;
			end
			F_MUL:  state_d = F_MIX;
			F_MIX:  state_d = last_q ? F_FIN1 : F_IDLE;
			F_FIN1: state_d = F_FIN2;
			F_FIN2: state_d = F_PUSH;
			F_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Running hashes, one multiply per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnv_q <= FNV_START;
			mur_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: if (in_valid && !hold) fnv_q <= (fnv_q ^ x) * FNV_MUL;
				F_MIX:  mur_q <= (hr << 2) + hr + MUR_ADD;
				F_FIN1: mur_q <= mur_q * MUR_F1;
				F_FIN2: mur_q <= ft * MUR_F2;
				F_PUSH: if (job_ready) begin
					fnv_q <= FNV_START;
					mur_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Per-byte scratch
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: if (in_valid && !hold) begin
				k_q    <= x * MUR_C1;
				op_q   <= opcode;
				last_q <= last_byte;
			end
			F_MUL: k_q <= {k_q[16:0], k_q[31:17]} * MUR_C2;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/cbf_queue.sv =====
// Two-entry queue of finished keys between the hash front and the back.
// Depends on cbf_pkg.
`default_nettype none
module cbf_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push_valid,
	output logic               push_ready,
	input  cbf_pkg::key_job_t  push_job,
	output logic               pop_valid,
	input  wire                pop_ready,
	output cbf_pkg::key_job_t  pop_job
);
	import cbf_pkg::*;

	key_job_t   slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = slot_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop)  rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wptr_q] <= push_job;
	end
endmodule
`default_nettype wire

// ===== rtl/core/cbf_back.sv =====
// Filter back: reduces hashes modulo the filter size, walks the index
// positions and updates the bit and count stores. Depends on cbf_pkg, cbf_ram.
`default_nettype none
module cbf_back #(
	parameter int MAX_BITS    = 1024,
	parameter int COUNT_WIDTH = 16,
	parameter int MAX_HASHES  = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire [$clog2(MAX_BITS+1)-1:0]         eff_size,
	input  wire [$clog2(MAX_HASHES+1)-1:0]       eff_k,
	input  wire                                  job_valid,
	output logic                                 job_ready,
	input  cbf_pkg::key_job_t                    job,
	output logic                                 clearing,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 found
);
	import cbf_pkg::*;

	localparam int AW = $clog2(MAX_BITS);
	localparam int SW = $clog2(MAX_BITS + 1);
	localparam int JW = $clog2(MAX_HASHES);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	back_state_t state_q, state_d;
	logic [31:0]          dfa_q, dma_q;
	logic [SW-1:0]        fa_q, ma_q, acc_q;
	logic [4:0]           it_q;
	logic [JW-1:0]        j_q;
	logic                 tgt_q, hit_q, out_valid_q, found_q;
	op_t                  op_q;
	logic [COUNT_WIDTH-1:0] cfa_q, cma_q;
	logic [AW:0]          clr_q;

	logic [SW:0]          rfa, rma, sfa, sma, asum;
	logic [SW-1:0]        cur_addr, acc_next;
	logic                 last_j, clr_done;
	logic                 bit_we, bit_wdata, bit_rdata;
	logic [AW-1:0]        bit_waddr, bit_raddr, cnt_waddr, cnt_raddr;
	logic                 cnt_we;
	logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata, cnt_new, c_fa_final;

	// One restoring step of each remainder
	assign rfa = {fa_q, dfa_q[31]};
	assign rma = {ma_q, dma_q[31]};
	assign sfa = (rfa >= {1'b0, eff_size}) ? rfa - {1'b0, eff_size} : rfa;
	assign sma = (rma >= {1'b0, eff_size}) ? rma - {1'b0, eff_size} : rma;

	// Further indices: previous plus ma, one reduction
	assign asum     = {1'b0, acc_q} + {1'b0, ma_q};
	assign acc_next = (asum >= {1'b0, eff_size}) ? SW'(asum - {1'b0, eff_size})
	                                             : SW'(asum);
	assign cur_addr = (j_q == '0) ? fa_q : ((j_q == JW'(1)) ? ma_q : acc_q);
	assign last_j   = (32'(j_q) + 32'd1) == 32'(eff_k);
	assign clr_done = (32'(clr_q) == 32'(MAX_BITS));

	assign cnt_new = (op_q == OP_ADD)
	                 ? ((cnt_rdata != CNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata)
	                 : ((cnt_rdata != '0) ? cnt_rdata - 1'b1 : cnt_rdata);
	assign c_fa_final = (fa_q == ma_q) ? cma_q : cfa_q;

	assign clearing  = (state_q == B_CLEAR);
	assign out_valid = out_valid_q;
	assign found     = found_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and store controls
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		bit_we    = 1'b0;
		bit_wdata = 1'b0;
		bit_waddr = cur_addr[AW-1:0];
		bit_raddr = cur_addr[AW-1:0];
		cnt_we    = 1'b0;
		cnt_wdata = cnt_new;
		cnt_waddr = tgt_q ? ma_q[AW-1:0] : fa_q[AW-1:0];
		cnt_raddr = tgt_q ? ma_q[AW-1:0] : fa_q[AW-1:0];
		case (state_q)
			B_CLEAR: begin
				bit_we    = !clr_done;
				cnt_we    = !clr_done;
				bit_waddr = clr_q[AW-1:0];
				cnt_waddr = clr_q[AW-1:0];
				cnt_wdata = '0;
				if (clr_done) state_d = B_IDLE;
			end
			B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) state_d = B_MOD;
			end
			B_MOD:  if (it_q == 5'd31) state_d = B_INIT;
			B_INIT: state_d = (op_q == OP_ADD) ? B_SET : B_QRD;
			B_SET: begin
				bit_we    = 1'b1;
				bit_wdata = 1'b1;
				if (last_j) state_d = B_CRD;
			end
			B_QRD:  state_d = B_QCHK;
			B_QCHK: begin
				if (last_j) begin
					state_d = (op_q == OP_DELETE && hit_q && bit_rdata) ? B_CRD : B_OUT;
				end else begin
					state_d = B_QRD;
				end
			end
			B_CRD:  state_d = B_CWR;
			B_CWR: begin
				cnt_we = 1'b1;
				if (!tgt_q) state_d = B_CRD;
				else        state_d = (op_q == OP_ADD) ? B_OUT : B_CLR0;
			end
			B_CLR0: begin
				bit_we    = (c_fa_final == '0);
				bit_waddr = fa_q[AW-1:0];
				state_d   = B_CLR1;
			end
			B_CLR1: begin
				bit_we    = (cma_q == '0);
				bit_waddr = ma_q[AW-1:0];
				state_d   = B_OUT;
			end
			B_OUT: if (!out_valid_q || out_ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_CLEAR && !clr_done) clr_q <= clr_q + 1'b1;
			if (state_q == B_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)                   out_valid_q <= 1'b0;
		end
	end

	// Working registers of the current key
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: if (job_valid) begin
				dfa_q <= job.fnv;
				dma_q <= job.mur;
				op_q  <= job.op;
				fa_q  <= '0;
				ma_q  <= '0;
				it_q  <= '0;
			end
			B_MOD: begin
				fa_q  <= SW'(sfa);
				ma_q  <= SW'(sma);
				dfa_q <= {dfa_q[30:0], 1'b0};
				dma_q <= {dma_q[30:0], 1'b0};
				it_q  <= it_q + 1'b1;
			end
			B_INIT: begin
				acc_q <= (({1'b0, fa_q} + {1'b0, ma_q}) >= {1'b0, eff_size})
				         ? SW'({1'b0, fa_q} + {1'b0, ma_q} - {1'b0, eff_size})
				         : SW'({1'b0, fa_q} + {1'b0, ma_q});
				j_q   <= '0;
				hit_q <= 1'b1;
				tgt_q <= 1'b0;
			end
			B_SET: if (!last_j) begin
				j_q   <= j_q + 1'b1;
				acc_q <= acc_next;
			end
			B_QCHK: begin
				hit_q <= hit_q & bit_rdata;
				if (!last_j) begin
					j_q   <= j_q + 1'b1;
					acc_q <= acc_next;
				end
			end
			B_CWR: begin
				if (tgt_q) cma_q <= cnt_new;
				else       cfa_q <= cnt_new;
				tgt_q <= 1'b1;
			end
			B_OUT: if (!out_valid_q || out_ready) found_q <= hit_q;
			default: ;
		endcase
	end

	cbf_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_bits (
		.clk   (clk),
		.we    (bit_we),
		.waddr (bit_waddr),
		.wdata (bit_wdata),
		.raddr (bit_raddr),
		.rdata (bit_rdata)
	);

	cbf_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BITS)) u_counts (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// A count write always follows its read
	a_cwr_after_crd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CWR |-> $past(state_q) == B_CRD)
		else $error("count write without a preceding read");

	// Probe addresses stay inside the filter in use
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SET || state_q == B_QRD) |-> (cur_addr < eff_size))
		else $error("probe address beyond filter size");

	// No store writes while waiting for work
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_IDLE |-> !bit_we && !cnt_we)
		else $error("store write while idle");

	// A key is only taken once the clearing pass has finished
	a_no_job_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CLEAR |-> !job_ready)
		else $error("job taken during clearing pass");
endmodule
`default_nettype wire

// ===== rtl/core/counting_bloom_filter_two_hash_top.sv =====
// Counting Bloom filter with two running hashes, one key byte per transaction.
// Each byte passes the hash front's capture, multiply and mix states; a last byte then
// runs FIN1, FIN2 and PUSH. Per key the back runs a 32-step modulo pair, then sets K bits
// and two counts (add), probes K bits (query) or probes, counts and clears bits (delete).
// After reset the stores are swept over all MAX_BITS entries; no input then.
// Reset (arst_n, asynchronous): filter_size = 1024, hash_count = 2, hashes restarted.
`default_nettype none
module counting_bloom_filter_two_hash_top #(
	parameter int MAX_BITS    = 1024,
	parameter int COUNT_WIDTH = 16,
	parameter int MAX_HASHES  = 16
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire [cbf_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire [cbf_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire [1:0]                              opcode,
	input  wire [7:0]                              key_byte,
	input  wire                                    last_byte,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic                                   found
);
	import cbf_pkg::*;

	localparam int SW = $clog2(MAX_BITS + 1);
	localparam int KW = $clog2(MAX_HASHES + 1);

	logic [10:0]   filter_size_q;
	logic [4:0]    hash_count_q;
	logic [SW-1:0] eff_size;
	logic [KW-1:0] eff_k;
	logic          clearing;
	logic          fj_valid, fj_ready, bj_valid, bj_ready;
	key_job_t      fj, bj;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_size_q <= 11'd1024;
			hash_count_q  <= 5'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILTER_SIZE: filter_size_q <= cfg_data;
				CFG_HASH_COUNT:  hash_count_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Clamp to the supported ranges
	always_comb begin
		if (filter_size_q == '0)                    eff_size = SW'(1);
		else if (32'(filter_size_q) > 32'(MAX_BITS)) eff_size = SW'(MAX_BITS);
		else                                        eff_size = SW'(filter_size_q);
		if (hash_count_q < 5'd2)                      eff_k = KW'(2);
		else if (32'(hash_count_q) > 32'(MAX_HASHES)) eff_k = KW'(MAX_HASHES);
		else                                          eff_k = KW'(hash_count_q);
	end

	cbf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (clearing),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.key_byte  (key_byte),
		.last_byte (last_byte),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job       (fj)
	);

	cbf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_job   (fj),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_job    (bj)
	);

	cbf_back #(
		.MAX_BITS    (MAX_BITS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.MAX_HASHES  (MAX_HASHES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_size  (eff_size),
		.eff_k     (eff_k),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job       (bj),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found)
	);
endmodule
`default_nettype wire

// ===== verif/tb_counting_bloom_filter_two_hash_top.sv =====
// Testbench for the two-hash counting Bloom filter: directed table then random keys,
// every result checked against a behavioural predictor held here.
// Depends on cbf_pkg and counting_bloom_filter_two_hash_top.
`timescale 1ns / 1ps
module tb_counting_bloom_filter_two_hash_top;
	import cbf_pkg::*;

	localparam int NBITS = 1024;
	localparam int NHASH = 16;
	localparam int CMAX = 65535;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = 2'd0;
	logic [7:0] key_byte = 8'd0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	counting_bloom_filter_two_hash_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .key_byte(key_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready), .found(found)
	);

	// Predictor state
	logic [31:0] fnv_h, mur_h;
	logic        bitmap [NBITS];
	int unsigned counts [NBITS];
	logic [10:0] size_reg;
	logic [4:0]  hashes_reg;

	logic found_q[$];
	bit   failed = 1'b0;
	int   idle_send = 0, idle_recv = 0;
	int   quiet = 0;

	function automatic logic [31:0] rotl(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Fold one byte into the running hashes; on a last byte work the filter
	function automatic void filter_predict(op_t op, logic [7:0] b, logic lst);
		logic [31:0] x, k, h, fa, ma, s, kk, idx;
		logic hit;
		x = {{24{b[7]}}, b};
		fnv_h = (fnv_h ^ x) * FNV_MUL;
		k = rotl(x * MUR_C1, 15) * MUR_C2;
		h = mur_h ^ k;
		h = (h << 13) | (h >> 13);
		mur_h = h * 5 + MUR_ADD;
		if (!lst)
			return;
		s = (size_reg == 0) ? 1 : (size_reg > NBITS) ? NBITS : size_reg;
		kk = (hashes_reg < 2) ? 2 : (hashes_reg > NHASH) ? NHASH : hashes_reg;
		h = mur_h * MUR_F1;
		h = h ^ (h >> 13);
		h = h * MUR_F2;
		h = h ^ (h >> 16);
		fa = fnv_h % s;
		ma = h % s;
		fnv_h = FNV_START;
		mur_h = '0;
		if (op == OP_ADD) begin
			bitmap[fa] = 1'b1;
			bitmap[ma] = 1'b1;
			if (counts[fa] < CMAX) counts[fa]++;
			if (counts[ma] < CMAX) counts[ma]++;
			for (int i = 3; i <= kk; i++) begin
				idx = (fa + i * ma) % s;
				bitmap[idx] = 1'b1;
			end
			found_q.push_back(1'b1);
			return;
		end
		hit = bitmap[fa] && bitmap[ma];
		for (int i = 3; i <= kk; i++) begin
			idx = (fa + i * ma) % s;
			if (!bitmap[idx]) hit = 1'b0;
		end
		if (op == OP_DELETE && hit) begin
			if (counts[fa] != 0) counts[fa]--;
			if (counts[ma] != 0) counts[ma]--;
			if (counts[fa] == 0) bitmap[fa] = 1'b0;
			if (counts[ma] == 0) bitmap[ma] = 1'b0;
		end
		found_q.push_back(hit);
	endfunction

	// Result checking and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (found_q.size() == 0) begin
					$error("unexpected transaction: found=%0b", found);
					failed <= 1'b1;
				end else begin
					if (found !== found_q[0]) begin
						$error("found: expected %0b, actual %0b", found_q[0], found);
						failed <= 1'b1;
					end
					void'(found_q.pop_front());
				end
			end
			out_ready <= ($urandom_range(99) >= idle_recv);
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Valid is dropped only for idle cycles or by drain, never between back-to-back bytes
	task automatic send_byte(op_t op, logic [7:0] b, logic lst);
		while ($urandom_range(99) < idle_send) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		filter_predict(op, b, lst);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (found_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FILTER_SIZE) size_reg = v;
		else hashes_reg = v[4:0];
	endtask

	// Random key of 1..6 bytes with a random opcode, mostly reused small keys
	task automatic random_key();
		int n;
		op_t op;
		n = $urandom_range(0, 5);
		op = op_t'($urandom_range(3));
		for (int i = 0; i < n; i++)
			send_byte(op_t'($urandom_range(3)),
				($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3) + 8'h7e),
				1'b0);
		send_byte(op, 8'($urandom_range(7) + 8'hfc), 1'b1);
	endtask

	typedef struct {
		op_t op;
		logic [7:0] b;
		logic lst;
		logic chk;
		logic want;
	} row_t;

	row_t stim [] = '{
		'{OP_QUERY, 8'h00, 1'b1, 1'b1, 1'b0},   // empty filter misses
		'{OP_DELETE, 8'hff, 1'b1, 1'b1, 1'b0},  // delete on empty filter
		'{OP_ADD, 8'h00, 1'b1, 1'b1, 1'b1},
		'{OP_QUERY, 8'h00, 1'b1, 1'b1, 1'b1},
		'{OP_ADD, 8'h80, 1'b0, 1'b0, 1'b0},     // sign-extended byte
		'{OP_ADD, 8'h7f, 1'b1, 1'b1, 1'b1},
		'{OP_SPARE, 8'h80, 1'b0, 1'b0, 1'b0},
		'{OP_SPARE, 8'h7f, 1'b1, 1'b0, 1'b0},   // spare opcode acts as query
		'{OP_DELETE, 8'h80, 1'b0, 1'b0, 1'b0},
		'{OP_DELETE, 8'h7f, 1'b1, 1'b0, 1'b0},
		'{OP_DELETE, 8'h00, 1'b1, 1'b0, 1'b0},
		'{OP_QUERY, 8'h00, 1'b1, 1'b0, 1'b0},
		'{OP_DELETE, 8'h00, 1'b1, 1'b0, 1'b0},  // count already at zero
		'{OP_ADD, 8'h55, 1'b0, 1'b0, 1'b0},
		'{OP_ADD, 8'haa, 1'b1, 1'b1, 1'b1},
		'{OP_QUERY, 8'h55, 1'b0, 1'b0, 1'b0},
		'{OP_QUERY, 8'haa, 1'b1, 1'b0, 1'b0}
	};

	initial begin
		int phase_idle [4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{16, 16}};
		int qlen;
		fnv_h = FNV_START;
		mur_h = '0;
		size_reg = 11'd1024;
		hashes_reg = 5'd2;
		for (int i = 0; i < NBITS; i++) begin
			bitmap[i] = 1'b0;
			counts[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// the block sweeps its stores after reset; in_ready holds it off

		// Directed table
		foreach (stim[r]) begin
			send_byte(stim[r].op, stim[r].b, stim[r].lst);
			qlen = found_q.size();
			if (stim[r].chk && stim[r].lst && qlen > 0 && found_q[qlen-1] !== stim[r].want) begin
				$error("found: expected %0b, actual %0b", stim[r].want, found_q[qlen-1]);
				failed = 1'b1;
			end
		end
		drain();

		// Tiny filter with out-of-range register values, then many hashes
		write_reg(CFG_FILTER_SIZE, 11'd0);
		write_reg(CFG_HASH_COUNT, 5'd0);
		for (int i = 0; i < 10; i++) random_key();
		drain();
		write_reg(CFG_FILTER_SIZE, 11'd2047);
		write_reg(CFG_HASH_COUNT, 5'd31);
		for (int i = 0; i < 10; i++) random_key();
		drain();

		// Random phases over several settings
		for (int p = 0; p < 8; p++) begin
			idle_send = phase_idle[p % 4][0];
			idle_recv = phase_idle[p % 4][1];
			write_reg(CFG_FILTER_SIZE, (p == 7) ? 11'd1 : 11'($urandom_range(1, 1024)));
			write_reg(CFG_HASH_COUNT, (p == 6) ? 5'd16 : 5'($urandom_range(2, 16)));
			for (int i = 0; i < 20; i++) random_key();
			drain();
		end
		idle_send = 0;
		idle_recv = 0;
		drain();

		if (!failed)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== counting_bloom_filter_two_hash_top.f =====
rtl/core/cbf_pkg.sv
rtl/core/cbf_ram.sv
rtl/core/cbf_front.sv
rtl/core/cbf_queue.sv
rtl/core/cbf_back.sv
rtl/core/counting_bloom_filter_two_hash_top.sv
verif/tb_counting_bloom_filter_two_hash_top.sv
